// ===== hdl/pdr_pkg.sv =====
// Package for the planar dead-reckoning integrator: constants, arctangent table, shared types.
`timescale 1ns / 1ps
package pdr_pkg;

  localparam int CORDIC_STEPS_DEF   = 24;
  localparam int TIME_FRAC_BITS_DEF = 20;
  localparam int ATAN_LEN           = 32;
  localparam int IDX_W              = 5;
  // Top step of the angle reduction; 2*pi << 28 covers every sum of yaw and its increment.
  localparam int WRAP_TOP           = 28;
  localparam int ACC_W              = 62;

  localparam logic signed [31:0] PI_Q      = 32'sd843314857;
  localparam logic signed [31:0] TWO_PI_Q  = 32'sd1686629714;
  localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
  localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;

  typedef logic signed [31:0] atan_tab_t [ATAN_LEN];

  // Arctangent of 2^-i in Q28, from the Taylor series at Q60, rounded to nearest.
  // Past 2^-27 only the leading term of the series is left.
  localparam atan_tab_t ATAN_TAB = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32,
    32'sd16,        32'sd8,         32'sd4,        32'sd2,
    32'sd1,         32'sd1,         32'sd0,        32'sd0
  };

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_CORD = 11'b00000000010,
    S_MC   = 11'b00000000100,
    S_MS   = 11'b00000001000,
    S_MX   = 11'b00000010000,
    S_MY   = 11'b00000100000,
    S_MW   = 11'b00001000000,
    S_ADD  = 11'b00010000000,
    S_WRAP = 11'b00100000000,
    S_FIN  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_e;

  typedef struct packed {
    logic             load;
    logic             cord;
    logic             mc;
    logic             ms;
    logic             mx;
    logic             my;
    logic             mw;
    logic             add;
    logic             wrap;
    logic             fin;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } pdr_cmd_t;

endpackage

// ===== hdl/pdr_ctrl.sv =====
// Sequencer for the integrator: steps the datapath through CORDIC, multiplies and wrap.
`timescale 1ns / 1ps
module pdr_ctrl import pdr_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pdr_cmd_t cmd_o
);

  localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             ovalid_q, ovalid_d;
  logic             in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    cmd_o.idx = cnt_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_CORD;
        end
      end
      S_CORD: begin
        cmd_o.cord = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == IDX_W'(STEPS - 1)) begin
          state_d = S_MC;
        end
      end
      S_MC: begin
        cmd_o.mc = 1'b1;
        state_d  = S_MS;
      end
      S_MS: begin
        cmd_o.ms = 1'b1;
        state_d  = S_MX;
      end
      S_MX: begin
        cmd_o.mx = 1'b1;
        state_d  = S_MY;
      end
      S_MY: begin
        cmd_o.my = 1'b1;
        state_d  = S_MW;
      end
      S_MW: begin
        cmd_o.mw = 1'b1;
        state_d  = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        cnt_d     = IDX_W'(WRAP_TOP);
        state_d   = S_WRAP;
      end
      S_WRAP: begin
        cmd_o.wrap = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        // The previous word must leave the output register first.
        if (!ovalid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ovalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_acc_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_CORD) && (cnt_q == '0))
    else $error("accepted word did not start the CORDIC");

  a_rose_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(state_q == S_OUT))
    else $error("output valid rose outside the output state");

  a_cord_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> (cnt_q < IDX_W'(STEPS)))
    else $error("CORDIC counter out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |-> !cmd_o.out_load)
    else $error("pending output word overwritten");

endmodule

// ===== hdl/pdr_dp.sv =====
// Datapath for the integrator: pose state, CORDIC, shared multiplier, angle reduction.
`timescale 1ns / 1ps
module pdr_dp import pdr_pkg::*; #(
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pdr_cmd_t           cmd_i,
  input  logic               kind_i,
  input  logic        [31:0] stamp_i,
  input  logic signed [23:0] rate_value_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [30:0] heading_o,
  output logic signed [23:0] forward_speed_o,
  output logic signed [23:0] yaw_rate_o
);

  localparam int TSH = TIME_FRAC_BITS - 12;

  // Pose state.
  logic signed [31:0] x_q, y_q;
  logic signed [30:0] yaw_q;
  logic signed [23:0] spd_q, trn_q;
  logic        [31:0] last_q;
  logic               started_q;

  // Working registers.
  logic signed [33:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic               neg_q;
  logic signed [31:0] dt_q;
  logic signed [25:0] vc_q, vs_q;
  logic signed [ACC_W-1:0] dx_q, dy_q, dyaw_q, r_q;

  // Output register.
  logic signed [31:0] ox_q, oy_q;
  logic signed [30:0] oh_q;
  logic signed [23:0] os_q, ot_q;

  logic        [31:0] base;
  logic signed [31:0] yaw_w, zf;
  logic               negf;
  logic signed [33:0] xs, ys, cos_v, sin_v;
  logic signed [31:0] atn;
  logic signed [25:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [59:0] prod;
  logic signed [ACC_W-1:0] prod_w, rnd30, rndt, dyaw_n;
  logic signed [ACC_W-1:0] sx, sy, m_k, r_n, r_fin;
  logic signed [31:0] sat_x, sat_y;

  assign base  = started_q ? last_q : stamp_i;
  assign yaw_w = 32'(yaw_q);

  always_comb begin
    zf   = yaw_w;
    negf = 1'b0;
    if (yaw_w > HALF_PI_Q) begin
      zf   = yaw_w - PI_Q;
      negf = 1'b1;
    end else if (yaw_w < -HALF_PI_Q) begin
      zf   = yaw_w + PI_Q;
      negf = 1'b1;
    end
  end

  assign xs  = cx_q >>> cmd_i.idx;
  assign ys  = cy_q >>> cmd_i.idx;
  assign atn = ATAN_TAB[cmd_i.idx];

  assign cos_v = neg_q ? -cx_q : cx_q;
  assign sin_v = neg_q ? -cy_q : cy_q;

  always_comb begin
    mul_a = 26'(spd_q);
    mul_b = cos_v;
    if (cmd_i.ms) begin
      mul_b = sin_v;
    end else if (cmd_i.mx) begin
      mul_a = vc_q;
      mul_b = 34'(dt_q);
    end else if (cmd_i.my) begin
      mul_a = vs_q;
      mul_b = 34'(dt_q);
    end else if (cmd_i.mw) begin
      mul_a = 26'(trn_q);
      mul_b = 34'(dt_q);
    end
  end

  assign prod   = 60'(mul_a) * 60'(mul_b);
  assign prod_w = ACC_W'(prod);
  assign rnd30  = (prod_w + (ACC_W'(1) <<< 29)) >>> 30;
  assign rndt   = (prod_w + (ACC_W'(1) <<< (TIME_FRAC_BITS - 1))) >>> TIME_FRAC_BITS;

  generate
    if (TSH > 0) begin : g_shr
      assign dyaw_n = (prod_w + (ACC_W'(1) <<< (TSH - 1))) >>> TSH;
    end else if (TSH == 0) begin : g_eq
      assign dyaw_n = prod_w;
    end else begin : g_shl
      assign dyaw_n = prod_w <<< (-TSH);
    end
  endgenerate

  assign sx = ACC_W'(x_q) + dx_q;
  assign sy = ACC_W'(y_q) + dy_q;

  always_comb begin
    sat_x = sx[31:0];
    if (sx > ACC_W'(32'sh7fffffff)) begin
      sat_x = 32'sh7fffffff;
    end else if (sx < -ACC_W'(33'sh080000000)) begin
      sat_x = 32'sh80000000;
    end
    sat_y = sy[31:0];
    if (sy > ACC_W'(32'sh7fffffff)) begin
      sat_y = 32'sh7fffffff;
    end else if (sy < -ACC_W'(33'sh080000000)) begin
      sat_y = 32'sh80000000;
    end
  end

  // One step of the reduction by 2*pi << k; the result then lies in [-m_k, m_k).
  assign m_k = ACC_W'(TWO_PI_Q) <<< cmd_i.idx;
  always_comb begin
    r_n = r_q;
    if (r_q >= m_k) begin
      r_n = r_q - m_k;
    end else if (r_q < -m_k) begin
      r_n = r_q + m_k;
    end
  end
  assign r_fin = ((r_q < 0) ? r_q + ACC_W'(TWO_PI_Q) : r_q) - ACC_W'(PI_Q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      yaw_q     <= '0;
      spd_q     <= '0;
      trn_q     <= '0;
      last_q    <= '0;
      started_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (kind_i) begin
          trn_q <= rate_value_i;
        end else begin
          spd_q <= rate_value_i;
        end
        last_q    <= stamp_i;
        started_q <= 1'b1;
      end
      if (cmd_i.add) begin
        x_q <= sat_x;
        y_q <= sat_y;
      end
      if (cmd_i.fin) begin
        yaw_q <= r_fin[30:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dt_q  <= $signed(stamp_i - base);
      cx_q  <= GAIN_Q30;
      cy_q  <= '0;
      cz_q  <= zf;
      neg_q <= negf;
    end
    if (cmd_i.cord) begin
      if (cz_q >= 0) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atn;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atn;
      end
    end
    if (cmd_i.mc) begin
      vc_q <= rnd30[25:0];
    end
    if (cmd_i.ms) begin
      vs_q <= rnd30[25:0];
    end
    if (cmd_i.mx) begin
      dx_q <= rndt;
    end
    if (cmd_i.my) begin
      dy_q <= rndt;
    end
    if (cmd_i.mw) begin
      dyaw_q <= dyaw_n;
    end
    if (cmd_i.add) begin
      r_q <= ACC_W'(yaw_q) + dyaw_q + ACC_W'(PI_Q);
    end
    if (cmd_i.wrap) begin
      r_q <= r_n;
    end
    if (cmd_i.out_load) begin
      ox_q <= x_q;
      oy_q <= y_q;
      oh_q <= yaw_q;
      os_q <= spd_q;
      ot_q <= trn_q;
    end
  end

  assign pos_x_o         = ox_q;
  assign pos_y_o         = oy_q;
  assign heading_o       = oh_q;
  assign forward_speed_o = os_q;
  assign yaw_rate_o      = ot_q;

endmodule

// ===== hdl/planar_dead_reckoning_integrator_top.sv =====
// Top level of the planar dead-reckoning integrator.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o  kind_i, stamp_i, rate_value_i
//   out      output     out_valid_o / out_ready_i pos_x_o, pos_y_o, heading_o,
//                                                forward_speed_o, yaw_rate_o
//
// A word passes from acceptance through the CORDIC (one step per cycle), the five
// multiplies, the position update, the 29-step heading reduction and a final
// heading step before its result enters the output register. The sequencer is
// idle again as the result becomes valid, so a new word waits for the last one.
// A new word is taken only while the sequencer is idle; one result may wait in the
// output register meanwhile, and a stalled output holds the next result back.
// Reset is asynchronous and clears the pose, held rates and timestamp history.
`timescale 1ns / 1ps
module planar_dead_reckoning_integrator_top import pdr_pkg::*; #(
  parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
  parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic        [31:0] stamp_i,
  input  logic signed [23:0] rate_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [30:0] heading_o,
  output logic signed [23:0] forward_speed_o,
  output logic signed [23:0] yaw_rate_o
);

  pdr_cmd_t cmd;

  pdr_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  pdr_dp #(
    .TIME_FRAC_BITS(TIME_FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .stamp_i        (stamp_i),
    .rate_value_i   (rate_value_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .heading_o      (heading_o),
    .forward_speed_o(forward_speed_o),
    .yaw_rate_o     (yaw_rate_o)
  );

endmodule
